// ===== rtl/rtnrp_pkg.sv =====
// Shared widths, status codes and latency constants for the RTN relative position block.
package rtnrp_pkg;

   localparam int POS_W    = 28;
   localparam int VEL_W    = 25;
   localparam int DIFF_W   = POS_W + 1;
   localparam int PROD_W   = POS_W + VEL_W;
   localparam int CROSS_W  = PROD_W + 1;
   localparam int DSQ_W    = 2 * DIFF_W - 1;
   localparam int D2_W     = 2 * DIFF_W;
   localparam int Q30_W    = 32;
   localparam int NORM_W   = 31;
   localparam int SQ_W     = 2 * NORM_W;
   localparam int QUO_W    = 31;
   localparam int DIV_W    = 32;
   localparam int SEP_W    = 30;
   localparam int LEN_W    = 30;
   localparam int STATUS_W = 2;
   localparam int WIDE_W   = 64;

   localparam int UNIT_LAT = 7 + SQ_W / 2 + QUO_W;

   localparam logic signed [Q30_W-1:0] Q30_ONE = 32'sd1073741824;
   localparam logic signed [SEP_W-1:0] SEP_MAX = {1'b0, {(SEP_W-1){1'b1}}};
   localparam logic signed [SEP_W-1:0] SEP_MIN = {1'b1, {(SEP_W-1){1'b0}}};

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_POS = 2'd1,
      STATUS_PARALLEL = 2'd2
   } status_type;

endpackage

// ===== rtl/rtnrp_delay.sv =====
// Enabled shift line that carries side data alongside the arithmetic stages.
module rtnrp_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);
   logic [W-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            line_ff[k] <= line_ff[k-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];

endmodule

// ===== rtl/rtnrp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with remainder.
module rtnrp_sqrt #(
   parameter int IN_W = 58
) (
   input  logic              clock,
   input  logic              en,
   input  logic [IN_W-1:0]   rad,
   output logic [IN_W/2-1:0] root,
   output logic [IN_W/2:0]   rem
);
   localparam int RW  = IN_W / 2;
   localparam int RMW = RW + 3;

   logic [RMW-1:0]  rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [IN_W-1:0] x_ff    [RW];

   for (genvar g = 0; g < RW; g++) begin : g_stage
      logic [RMW-1:0]  src_rem;
      logic [RW-1:0]   src_root;
      logic [IN_W-1:0] src_x;
      logic [RMW-1:0]  t;
      logic [RMW-1:0]  trial;
      logic            ge;
      logic [RMW-1:0]  rem_in;
      logic [RW-1:0]   root_in;
      logic [IN_W-1:0] x_in;

      if (g == 0) begin : g_first
         assign src_rem  = '0;
         assign src_root = '0;
         assign src_x    = rad;
      end else begin : g_next
         assign src_rem  = rem_ff[g-1];
         assign src_root = root_ff[g-1];
         assign src_x    = x_ff[g-1];
      end

      always_comb begin
         t       = {src_rem[RW:0], src_x[IN_W-1 -: 2]};
         trial   = {1'b0, src_root, 2'b01};
         ge      = (t >= trial);
         rem_in  = ge ? (t - trial) : t;
         root_in = {src_root[RW-2:0], ge};
         x_in    = src_x << 2;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            x_ff[g]    <= x_in;
         end
      end
   end

   assign root = root_ff[RW-1];
   assign rem  = rem_ff[RW-1][RW:0];

endmodule

// ===== rtl/rtnrp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rtnrp_div #(
   parameter int QW = 31,
   parameter int DW = 32
) (
   input  logic               clock,
   input  logic               en,
   input  logic [QW+DW-2:0]   num,
   input  logic [DW-1:0]      den,
   output logic [QW-1:0]      quo
);
   localparam int NW = QW + DW - 1;

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [DW-1:0] den_ff [QW];

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [DW-1:0] src_rem;
      logic [QW-1:0] src_quo;
      logic [QW-1:0] src_low;
      logic [DW-1:0] src_den;
      logic [DW:0]   t;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] quo_in;
      logic [QW-1:0] low_in;

      if (g == 0) begin : g_first
         assign src_rem = DW'(num[NW-1:QW]);
         assign src_quo = '0;
         assign src_low = num[QW-1:0];
         assign src_den = den;
      end else begin : g_next
         assign src_rem = rem_ff[g-1];
         assign src_quo = quo_ff[g-1];
         assign src_low = low_ff[g-1];
         assign src_den = den_ff[g-1];
      end

      always_comb begin
         t      = {src_rem, src_low[QW-1]};
         ge     = (t >= {1'b0, src_den});
         rem_in = ge ? DW'(t - {1'b0, src_den}) : t[DW-1:0];
         quo_in = {src_quo[QW-2:0], ge};
         low_in = src_low << 1;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
            low_ff[g] <= low_in;
            den_ff[g] <= src_den;
         end
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

// ===== rtl/rtnrp_unit.sv =====
// Pipelined Q1.30 unit vector of a signed integer three-vector.
module rtnrp_unit #(
   parameter int AW = 28
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [AW-1:0]                vec   [3],
   output logic signed [rtnrp_pkg::Q30_W-1:0]  u_vec [3]
);
   import rtnrp_pkg::*;

   localparam int LW      = $clog2(AW + 1);
   localparam int RW      = SQ_W / 2;
   localparam int WW      = AW + NORM_W;
   localparam int NRM_DLY = 2 + RW;
   localparam int SGN_DLY = 5 + RW + QUO_W;

   logic [AW-1:0]     mag_ff  [3];
   logic [2:0]        sgn_ff;
   logic [AW-1:0]     mag2_ff [3];
   logic [LW-1:0]     len_ff;
   logic [NORM_W-1:0] nrm_ff  [3];
   logic [SQ_W-1:0]   sq_ff   [3];
   logic [SQ_W-1:0]   sum_ff;
   logic [SQ_W-1:0]   num_ff  [3];
   logic [DIV_W-1:0]  den_ff;
   logic signed [Q30_W-1:0] u_ff [3];

   logic [AW-1:0]       orv;
   logic [LW-1:0]       len_in;
   logic [LW:0]         lsh;
   logic [LW:0]         rsh;
   logic [NORM_W-1:0]   nrm_in [3];
   logic [RW-1:0]       root;
   logic [3*NORM_W-1:0] nrm_dly;
   logic [2:0]          sgn_dly;
   logic [QUO_W-1:0]    quo [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= vec[i][AW-1] ? AW'(-vec[i]) : AW'(vec[i]);
            sgn_ff[i] <= vec[i][AW-1];
         end
      end
   end

   always_comb begin
      orv    = mag_ff[0] | mag_ff[1] | mag_ff[2];
      len_in = '0;
      for (int b = 0; b < AW; b++) begin
         if (orv[b]) begin
            len_in = LW'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff  <= len_in;
         mag2_ff <= mag_ff;
      end
   end

   always_comb begin
      logic [WW-1:0] ext;
      logic [WW-1:0] half;
      lsh = (LW+1)'(NORM_W - 1) - (LW+1)'(len_ff);
      rsh = (LW+1)'(len_ff) - (LW+1)'(NORM_W - 1);
      for (int i = 0; i < 3; i++) begin
         ext  = WW'(mag2_ff[i]);
         half = WW'(1) << (rsh - (LW+1)'(1));
         if ((LW+1)'(len_ff) > (LW+1)'(NORM_W - 1)) begin
            nrm_in[i] = NORM_W'((ext + half) >> rsh);
         end else begin
            nrm_in[i] = NORM_W'(ext << lsh);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nrm_ff <= nrm_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(nrm_ff[i]) * SQ_W'(nrm_ff[i]);
         end
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   rtnrp_sqrt #(.IN_W(SQ_W)) u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum_ff),
      .root  (root),
      .rem   ()
   );

   rtnrp_delay #(.W(3*NORM_W), .DEPTH(NRM_DLY)) u_nrm_dly (
      .clock (clock),
      .en    (en),
      .din   ({nrm_ff[2], nrm_ff[1], nrm_ff[0]}),
      .dout  (nrm_dly)
   );

   rtnrp_delay #(.W(3), .DEPTH(SGN_DLY)) u_sgn_dly (
      .clock (clock),
      .en    (en),
      .din   (sgn_ff),
      .dout  (sgn_dly)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= {nrm_dly[i*NORM_W +: NORM_W], RW'(0)} + SQ_W'(root);
         end
         den_ff <= {root, 1'b0};
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_div
      rtnrp_div #(.QW(QUO_W), .DW(DIV_W)) u_div (
         .clock (clock),
         .en    (en),
         .num   (num_ff[i]),
         .den   (den_ff),
         .quo   (quo[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i] <= sgn_dly[i] ? -$signed(Q30_W'(quo[i])) : $signed(Q30_W'(quo[i]));
         end
      end
   end

   assign u_vec = u_ff;

endmodule

// ===== rtl/rtn_relative_position.sv =====
// Top level of the RTN relative position pipeline.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  p1_x..p1_z, vel_x..vel_z, p2_x..p2_z
//   rsp_      out        rsp_valid/rsp_stall  radial_sep, along_sep, cross_sep,
//                                             sep_length, frame_status
//
// One item enters per cycle while req_stall is low.
// The latency is set by the unit-vector path: a 31-stage square root followed by
// 31-stage dividers, one bit per stage.
// Reset clears only the valid bits that travel with the data.
// While a result is held with rsp_stall high, the whole pipeline freezes.
module rtn_relative_position (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p1_x,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p1_y,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p1_z,
   input  logic signed [rtnrp_pkg::VEL_W-1:0]    req_vel_x,
   input  logic signed [rtnrp_pkg::VEL_W-1:0]    req_vel_y,
   input  logic signed [rtnrp_pkg::VEL_W-1:0]    req_vel_z,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p2_x,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p2_y,
   input  logic signed [rtnrp_pkg::POS_W-1:0]    req_p2_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rtnrp_pkg::SEP_W-1:0]    rsp_radial_sep,
   output logic signed [rtnrp_pkg::SEP_W-1:0]    rsp_along_sep,
   output logic signed [rtnrp_pkg::SEP_W-1:0]    rsp_cross_sep,
   output logic [rtnrp_pkg::LEN_W-1:0]           rsp_sep_length,
   output logic [rtnrp_pkg::STATUS_W-1:0]        rsp_frame_status
);
   import rtnrp_pkg::*;

   localparam int LAT     = UNIT_LAT + 8;
   localparam int LR_W    = D2_W / 2;
   localparam int D_DLY   = LAT - 4;
   localparam int ST_DLY  = LAT - 7;
   localparam int LEN_DLY = LAT - 5 - LR_W;

   function automatic logic signed [WIDE_W-1:0] rnd30(input logic signed [WIDE_W-1:0] x);
      logic [WIDE_W-1:0] mag;
      mag = x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
      mag = (mag + (WIDE_W'(1) << 29)) >> 30;
      return x[WIDE_W-1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [SEP_W-1:0] sat_sep(input logic signed [WIDE_W-1:0] x);
      if (x > WIDE_W'(SEP_MAX)) begin
         return SEP_MAX;
      end else if (x < WIDE_W'(SEP_MIN)) begin
         return SEP_MIN;
      end
      return SEP_W'(x);
   endfunction

   logic adv;
   logic [LAT-2:0] vld_ff;
   logic rsp_valid_ff;

   logic signed [POS_W-1:0]  r_a_ff [3];
   logic signed [VEL_W-1:0]  v_a_ff [3];
   logic signed [DIFF_W-1:0] d_a_ff [3];

   logic signed [PROD_W-1:0] pa_b_ff [3];
   logic signed [PROD_W-1:0] pb_b_ff [3];
   logic [DSQ_W-1:0]         dsq_b_ff [3];
   logic signed [POS_W-1:0]  r_b_ff [3];
   logic                     rzero_b_ff;

   logic signed [CROSS_W-1:0] w_c_ff [3];
   logic signed [POS_W-1:0]   r_c_ff [3];
   logic [D2_W-1:0]           d2_c_ff;
   status_type                status_c_ff;

   logic signed [Q30_W-1:0] rh_u [3];
   logic signed [Q30_W-1:0] wh_u [3];

   logic signed [WIDE_W-1:0] sp_a_ff [3];
   logic signed [WIDE_W-1:0] sp_b_ff [3];
   logic signed [Q30_W-1:0]  rh_s1_ff [3];
   logic signed [Q30_W-1:0]  wh_s1_ff [3];

   logic signed [Q30_W-1:0]  ax_ff [3][3];
   status_type               status_s2_ff;
   logic signed [WIDE_W-1:0] prod_ff [3][3];
   status_type               status_p1_ff;
   logic signed [WIDE_W-1:0] sum_ff [3];
   status_type               status_p2_ff;

   logic [LR_W-1:0]     len_root;
   logic [LR_W:0]       len_rem;
   logic [LEN_W-1:0]    len_r_ff;
   logic [LEN_W-1:0]    len_dly;
   logic [3*DIFF_W-1:0] d_dly;
   logic [STATUS_W-1:0] st_dly;

   logic signed [Q30_W-1:0] sh_s2 [3];

   logic signed [SEP_W-1:0]    rsp_radial_sep_ff;
   logic signed [SEP_W-1:0]    rsp_along_sep_ff;
   logic signed [SEP_W-1:0]    rsp_cross_sep_ff;
   logic [LEN_W-1:0]           rsp_sep_length_ff;
   logic [STATUS_W-1:0]        rsp_frame_status_ff;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign adv       = ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[LAT-3:0], req_valid};
         rsp_valid_ff <= vld_ff[LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_a_ff[0] <= req_p1_x;
         r_a_ff[1] <= req_p1_y;
         r_a_ff[2] <= req_p1_z;
         v_a_ff[0] <= req_vel_x;
         v_a_ff[1] <= req_vel_y;
         v_a_ff[2] <= req_vel_z;
         d_a_ff[0] <= DIFF_W'(req_p2_x) - DIFF_W'(req_p1_x);
         d_a_ff[1] <= DIFF_W'(req_p2_y) - DIFF_W'(req_p1_y);
         d_a_ff[2] <= DIFF_W'(req_p2_z) - DIFF_W'(req_p1_z);
      end
   end

   always_ff @(posedge clock) begin
      logic signed [D2_W-1:0] sq;
      if (adv) begin
         pa_b_ff[0] <= r_a_ff[1] * v_a_ff[2];
         pb_b_ff[0] <= r_a_ff[2] * v_a_ff[1];
         pa_b_ff[1] <= r_a_ff[2] * v_a_ff[0];
         pb_b_ff[1] <= r_a_ff[0] * v_a_ff[2];
         pa_b_ff[2] <= r_a_ff[0] * v_a_ff[1];
         pb_b_ff[2] <= r_a_ff[1] * v_a_ff[0];
         for (int i = 0; i < 3; i++) begin
            sq          = d_a_ff[i] * d_a_ff[i];
            dsq_b_ff[i] <= sq[DSQ_W-1:0];
         end
         r_b_ff     <= r_a_ff;
         rzero_b_ff <= (r_a_ff[0] == '0) && (r_a_ff[1] == '0) && (r_a_ff[2] == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            w_c_ff[i] <= CROSS_W'(pa_b_ff[i]) - CROSS_W'(pb_b_ff[i]);
         end
         r_c_ff  <= r_b_ff;
         d2_c_ff <= D2_W'(dsq_b_ff[0]) + D2_W'(dsq_b_ff[1]) + D2_W'(dsq_b_ff[2]);
         if (rzero_b_ff) begin
            status_c_ff <= STATUS_ZERO_POS;
         end else if ((pa_b_ff[0] == pb_b_ff[0]) && (pa_b_ff[1] == pb_b_ff[1]) &&
                      (pa_b_ff[2] == pb_b_ff[2])) begin
            status_c_ff <= STATUS_PARALLEL;
         end else begin
            status_c_ff <= STATUS_OK;
         end
      end
   end

   rtnrp_unit #(.AW(POS_W)) u_rhat (
      .clock (clock),
      .en    (adv),
      .vec   (r_c_ff),
      .u_vec (rh_u)
   );

   rtnrp_unit #(.AW(CROSS_W)) u_what (
      .clock (clock),
      .en    (adv),
      .vec   (w_c_ff),
      .u_vec (wh_u)
   );

   rtnrp_sqrt #(.IN_W(D2_W)) u_len_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (d2_c_ff),
      .root  (len_root),
      .rem   (len_rem)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         len_r_ff <= LEN_W'(len_root) + LEN_W'(len_rem > (LR_W+1)'(len_root));
      end
   end

   rtnrp_delay #(.W(LEN_W), .DEPTH(LEN_DLY)) u_len_dly (
      .clock (clock),
      .en    (adv),
      .din   (len_r_ff),
      .dout  (len_dly)
   );

   rtnrp_delay #(.W(3*DIFF_W), .DEPTH(D_DLY)) u_d_dly (
      .clock (clock),
      .en    (adv),
      .din   ({d_a_ff[2], d_a_ff[1], d_a_ff[0]}),
      .dout  (d_dly)
   );

   rtnrp_delay #(.W(STATUS_W), .DEPTH(ST_DLY)) u_st_dly (
      .clock (clock),
      .en    (adv),
      .din   (status_c_ff),
      .dout  (st_dly)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_a_ff[0] <= wh_u[1] * rh_u[2];
         sp_b_ff[0] <= wh_u[2] * rh_u[1];
         sp_a_ff[1] <= wh_u[2] * rh_u[0];
         sp_b_ff[1] <= wh_u[0] * rh_u[2];
         sp_a_ff[2] <= wh_u[0] * rh_u[1];
         sp_b_ff[2] <= wh_u[1] * rh_u[0];
         rh_s1_ff   <= rh_u;
         wh_s1_ff   <= wh_u;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_s2[i] = Q30_W'(rnd30(sp_a_ff[i] - sp_b_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         status_s2_ff <= status_type'(st_dly);
         if (status_type'(st_dly) != STATUS_OK) begin
            for (int a = 0; a < 3; a++) begin
               for (int c = 0; c < 3; c++) begin
                  ax_ff[a][c] <= (a == c) ? Q30_ONE : '0;
               end
            end
         end else begin
            ax_ff[0] <= rh_s1_ff;
            ax_ff[1] <= sh_s2;
            ax_ff[2] <= wh_s1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[a][c] <= $signed(d_dly[c*DIFF_W +: DIFF_W]) * ax_ff[a][c];
            end
            sum_ff[a] <= prod_ff[a][0] + prod_ff[a][1] + prod_ff[a][2];
         end
         status_p1_ff <= status_s2_ff;
         status_p2_ff <= status_p1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_radial_sep_ff   <= sat_sep(rnd30(sum_ff[0]));
         rsp_along_sep_ff    <= sat_sep(rnd30(sum_ff[1]));
         rsp_cross_sep_ff    <= sat_sep(rnd30(sum_ff[2]));
         rsp_sep_length_ff   <= len_dly;
         rsp_frame_status_ff <= status_p2_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_radial_sep   = rsp_radial_sep_ff;
   assign rsp_along_sep    = rsp_along_sep_ff;
   assign rsp_cross_sep    = rsp_cross_sep_ff;
   assign rsp_sep_length   = rsp_sep_length_ff;
   assign rsp_frame_status = rsp_frame_status_ff;

`ifndef SYNTH
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("Accepted item did not enter the first stage.");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(vld_ff))
      else $error("Pipeline moved while the result was held.");

   a_fallback_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_frame_status_ff != STATUS_OK) |->
         (rsp_radial_sep_ff[SEP_W-1] == rsp_radial_sep_ff[SEP_W-2]) &&
         (rsp_along_sep_ff[SEP_W-1] == rsp_along_sep_ff[SEP_W-2]) &&
         (rsp_cross_sep_ff[SEP_W-1] == rsp_cross_sep_ff[SEP_W-2]))
      else $error("Inertial fallback gave a separation beyond the difference range.");
`endif

endmodule
